### rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned IFACE_W    = 4;
    localparam int unsigned IN_DATA_W  = 136;
    localparam int unsigned OUT_DATA_W = 104;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_MISS  = 2'd1,
        ST_ADDED = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // one routing entry, dest in the lowest bits
    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [ADDR_W-1:0]  dest;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic start;
        logic vld;
        logic last;
    } t_scan_ctl;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_res;

endpackage

`default_nettype wire

### rtl/lpm_ram.sv
`default_nettype none

module lpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/lpm_scan.sv
`default_nettype none

module lpm_scan
    import lpm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_scan_ctl         i_ctl,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire t_entry            i_entry,
    output t_scan_res              o_res,
    output t_entry                 o_best
);

    logic   r_busy;
    logic   r_have;
    logic   r_done;
    t_entry r_best;

    logic w_take;
    logic w_host_hit;
    logic w_match;

    assign w_take     = r_busy && i_ctl.vld;
    assign w_host_hit = w_take && (i_entry.mask == '0) && (i_entry.dest == i_addr);
    assign w_match    = w_take && (i_entry.mask != '0)
                        && (((i_entry.dest ^ i_addr) & i_entry.mask) == '0)
                        && (!r_have || (i_entry.mask > r_best.mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_have <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_have <= 1'b0;
            end else if (w_host_hit) begin
                // exact host route ends the scan at once
                r_best <= i_entry;
                r_have <= 1'b1;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (w_take) begin
                if (w_match) begin
                    r_best <= i_entry;
                    r_have <= 1'b1;
                end
                if (i_ctl.last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_have;
    assign o_best      = r_best;

endmodule

`default_nettype wire

### rtl/longest_prefix_match_table.sv
// an add is answered without a table scan; a lookup scans the stored entries in order,
// ends early on a host route hit, and on an empty table is answered without a scan
// throughput: one item at a time; a lookup is bound by the single read port
// of the entry ram, which is scanned one entry per cycle
// reset: synchronous active low, clears the entry count and all control state;
// the entry ram is not cleared, only entries below the count are ever read
`default_nettype none

module longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // entry_dest, entry_gateway, entry_mask, entry_iface, lookup_addr
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // func
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // hit_dest, hit_gateway, hit_mask, hit_iface
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [1:0]                 o_m_axis_tuser
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_issue;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic [ADDR_W-1:0] r_addr;
    t_status           r_res_status;
    t_entry            r_res_data;
    logic              r_out_valid;
    t_status           r_out_status;
    t_entry            r_out_data;

    logic      w_s_accept;
    logic      w_full;
    logic      w_idx_last;
    logic      w_wr_en;
    t_entry    w_in_entry;
    t_entry    w_rd_entry;
    t_entry    w_best;
    t_scan_ctl w_ctl;
    t_scan_res w_res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CW'(TABLE_DEPTH));
    assign w_idx_last      = (r_idx == (r_count - CW'(1)));
    assign w_in_entry      = t_entry'(i_s_axis_tdata[ENTRY_W-1:0]);
    assign w_wr_en         = w_s_accept && (i_s_axis_tuser == FUNC_ADD) && !w_full;

    lpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_in_entry),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_entry)
    );

    assign w_ctl.start = w_s_accept && (i_s_axis_tuser == FUNC_LOOKUP) && (r_count != '0);
    assign w_ctl.vld   = r_rd_vld;
    assign w_ctl.last  = r_rd_last;

    lpm_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_addr  (r_addr),
        .i_entry (w_rd_entry),
        .o_res   (w_res),
        .o_best  (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld  <= r_issue && (r_state == S_SCAN);
            r_rd_last <= r_issue && w_idx_last;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_accept) begin
                        r_res_data <= '0;
                        r_state    <= S_RESULT;
                        if (i_s_axis_tuser == FUNC_ADD) begin
                            if (w_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_ADDED;
                                r_count      <= r_count + CW'(1);
                            end
                        end else begin
                            r_addr <= i_s_axis_tdata[ENTRY_W +: ADDR_W];
                            if (r_count == '0) begin
                                r_res_status <= ST_MISS;
                            end else begin
                                r_idx   <= '0;
                                r_issue <= 1'b1;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (w_idx_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                    if (w_res.done) begin
                        r_issue      <= 1'b0;
                        r_res_status <= w_res.found ? ST_FOUND : ST_MISS;
                        r_res_data   <= w_res.found ? w_best : '0;
                        r_state      <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_data   <= r_res_data;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - ENTRY_W)'(0), r_out_data};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

### rtl/lpm_chk.sv
`default_nettype none

module lpm_chk
    import lpm_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic [1:0]            o_m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // only a found result carries entry fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_MISS || o_m_axis_tuser == ST_ADDED
            || o_m_axis_tuser == ST_FULL) |-> o_m_axis_tdata == '0)
        else $error("non-hit result with nonzero fields");

    // one item in flight: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accepted word");

    // an add never takes the scan path: with no result word pending, it goes through S_RESULT into the output register
    a_add_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == FUNC_ADD)
            && !o_m_axis_tvalid |=> ##1 o_m_axis_tvalid
            && (o_m_axis_tuser == ST_ADDED || o_m_axis_tuser == ST_FULL))
        else $error("add result missing");

endmodule

bind longest_prefix_match_table lpm_chk u_lpm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
